[design/rsch_pkg.sv]
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types and constants of the range sensor channel health supervisor.
// ----------------------------------------------------------------------------
package rsch_pkg;

  localparam int CHANNELS     = 4;
  localparam int WINDOW_DEPTH = 16;

  localparam int CH_W   = 2;   // channel field width
  localparam int CNT_W  = 5;   // window count width
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;  // widest configuration register
  localparam int IDX_W  = 3;

  localparam logic [15:0] BUS_FAIL_CODE = 16'hFFFF;
  localparam logic [7:0]  IO_FAIL_MAX   = 8'hFF;

  typedef enum logic [IDX_W-1:0] {
    REG_STALE_TIMEOUT = 3'd0,
    REG_IO_FAIL_LIMIT = 3'd1,
    REG_OUT_OF_RANGE  = 3'd2,
    REG_DROPOUT_MISS  = 3'd3,
    REG_MIN_VALID     = 3'd4,
    REG_RECOVER_RETRY = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    H_OFFLINE = 2'd0,
    H_WARMING = 2'd1,
    H_ONLINE  = 2'd2
  } health_t;

  typedef enum logic [1:0] {
    DEMOTE_NONE    = 2'd0,
    DEMOTE_STALE   = 2'd1,
    DEMOTE_IO_FAIL = 2'd2
  } demote_t;

  typedef struct packed {
    logic [15:0] stale_timeout_ms;
    logic [7:0]  io_fail_limit;
    logic [15:0] range_limit_mm;
    logic [3:0]  miss_limit;
    logic [4:0]  trust_samples;
    logic [15:0] retry_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        health;
    logic [3:0]        miss_count;
    logic [7:0]        io_fail_count;
    logic [TIME_W-1:0] last_activity_ms;
    logic [TIME_W-1:0] retry_deadline_ms;
    logic [CNT_W-1:0]  sample_count;
  } chan_state_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_ms;
    logic              data_ready;
    logic [15:0]       range_mm;
    logic              init_ok;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [1:0]       health;
    logic             recovery_attempted;
    logic [1:0]       demote_reason;
    logic             sample_accepted;
    logic             window_cleared;
    logic [CNT_W-1:0] window_count;
    logic             reading_valid;
  } result_t;

endpackage

[design/rsch_cfg.sv]
// ----------------------------------------------------------------------------
// rsch_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rsch_cfg
  import rsch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_timeout_ms <= 16'd1000;
      cfg_r.io_fail_limit    <= 8'd3;
      cfg_r.range_limit_mm   <= 16'd8190;
      cfg_r.miss_limit       <= 4'd3;
      cfg_r.trust_samples    <= 5'd3;
      cfg_r.retry_gap_ms     <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STALE_TIMEOUT: cfg_r.stale_timeout_ms <= cfg_wdata;
        REG_IO_FAIL_LIMIT: cfg_r.io_fail_limit    <= cfg_wdata[7:0];
        REG_OUT_OF_RANGE:  cfg_r.range_limit_mm   <= cfg_wdata;
        REG_DROPOUT_MISS:  cfg_r.miss_limit       <= cfg_wdata[3:0];
        REG_MIN_VALID:     cfg_r.trust_samples    <= cfg_wdata[4:0];
        REG_RECOVER_RETRY: cfg_r.retry_gap_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/rsch_update.sv]
// ----------------------------------------------------------------------------
// rsch_update
// Next-state and result logic for one poll visit of one channel.
// ----------------------------------------------------------------------------
module rsch_update
  import rsch_pkg::*;
(
  input  cfg_t        cfg,
  input  item_t       item,
  input  chan_state_t cur,
  output chan_state_t nxt,
  output result_t     res
);

  logic [TIME_W-1:0] retry_at;
  logic [TIME_W-1:0] retry_diff;
  logic [TIME_W-1:0] idle_time;
  logic [7:0]        io_inc;
  logic [3:0]        miss_inc;
  logic              attempted;
  logic              accepted;
  logic              cleared;
  logic [1:0]        reason;

  assign retry_at   = item.now_ms + {16'd0, cfg.retry_gap_ms};
  assign retry_diff = item.now_ms - cur.retry_deadline_ms;
  assign idle_time  = item.now_ms - cur.last_activity_ms;
  assign io_inc     = (cur.io_fail_count != IO_FAIL_MAX) ? cur.io_fail_count + 8'd1
                                                         : cur.io_fail_count;
  assign miss_inc   = cur.miss_count + 4'd1;

  always_comb begin
    nxt       = cur;
    attempted = 1'b0;
    accepted  = 1'b0;
    cleared   = 1'b0;
    reason    = DEMOTE_NONE;

    if (cur.health == H_OFFLINE) begin
      // The deadline has been reached when the wrapped difference is not negative.
      if (!retry_diff[TIME_W-1]) begin
        attempted             = 1'b1;
        cleared               = 1'b1;
        nxt.retry_deadline_ms = retry_at;
        nxt.sample_count      = '0;
        if (item.init_ok) begin
          nxt.health           = H_WARMING;
          nxt.miss_count       = '0;
          nxt.io_fail_count    = '0;
          nxt.last_activity_ms = item.now_ms;
        end
      end
    end else if (!item.data_ready) begin
      if (idle_time > {16'd0, cfg.stale_timeout_ms}) begin
        nxt.health            = H_OFFLINE;
        nxt.sample_count      = '0;
        nxt.retry_deadline_ms = retry_at;
        reason                = DEMOTE_STALE;
        cleared               = 1'b1;
      end
    end else if (item.range_mm == BUS_FAIL_CODE) begin
      nxt.io_fail_count = io_inc;
      if (io_inc >= cfg.io_fail_limit) begin
        nxt.health            = H_OFFLINE;
        nxt.sample_count      = '0;
        nxt.retry_deadline_ms = retry_at;
        reason                = DEMOTE_IO_FAIL;
        cleared               = 1'b1;
      end
    end else begin
      nxt.io_fail_count    = '0;
      nxt.last_activity_ms = item.now_ms;
      if (item.range_mm < cfg.range_limit_mm) begin
        nxt.miss_count = '0;
        if (cur.sample_count < CNT_W'(WINDOW_DEPTH)) begin
          nxt.sample_count = cur.sample_count + CNT_W'(1);
        end
        accepted = 1'b1;
      end else if (cur.miss_count < cfg.miss_limit) begin
        nxt.miss_count = miss_inc;
        if (miss_inc == cfg.miss_limit) begin
          nxt.sample_count = '0;
          cleared          = 1'b1;
        end
      end
      // Warm-up ends on enough samples or on confirmed absence of a target.
      if (cur.health == H_WARMING &&
          (nxt.sample_count >= cfg.trust_samples ||
           nxt.miss_count >= cfg.miss_limit)) begin
        nxt.health = H_ONLINE;
      end
    end
  end

  assign res.channel_out        = item.channel;
  assign res.health             = nxt.health;
  assign res.recovery_attempted = attempted;
  assign res.demote_reason      = reason;
  assign res.sample_accepted    = accepted;
  assign res.window_cleared     = cleared;
  assign res.window_count       = nxt.sample_count;
  assign res.reading_valid      = (nxt.health == H_ONLINE) &&
                                  (nxt.sample_count >= cfg.trust_samples);

endmodule

[design/range_sensor_channel_health_top.sv]
// ----------------------------------------------------------------------------
// range_sensor_channel_health_top
// Per-channel health supervisor for an array of range sensors.
//
//   Channel  Ports                                         Handshake
//   input    in_channel, in_now_ms, in_data_ready,         in_valid / in_ready
//            in_range_mm, in_init_ok
//   result   out_channel_out, out_health, ...              out_valid / out_ready
//   config   cfg_index, cfg_wdata                          cfg_we, no wait
//
// One item per cycle is sustained while the result side is not stalled; each item
// is held first in the input register, then as a result in the result register.
// Channel state is written when an item moves into the result register, so
// the next item in the input register always sees up-to-date state.
// A stall on the result side holds both registers; the input register still takes
// an item while a finished result waits, if it is empty. Reset is synchronous.
// ----------------------------------------------------------------------------
module range_sensor_channel_health_top
  import rsch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_channel,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              in_data_ready,
  input  logic [15:0]       in_range_mm,
  input  logic              in_init_ok,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_channel_out,
  output logic [1:0]        out_health,
  output logic              out_recovery_attempted,
  output logic [1:0]        out_demote_reason,
  output logic              out_sample_accepted,
  output logic              out_window_cleared,
  output logic [CNT_W-1:0]  out_window_count,
  output logic              out_reading_valid,

  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t        cfg;
  item_t       s1_item_r;
  logic        s1_valid_r;
  result_t     out_res_r;
  logic        out_valid_r;
  chan_state_t st_r [CHANNELS];
  chan_state_t cur_st;
  chan_state_t nxt_st;
  result_t     res_nxt;
  logic        s1_advance;
  logic        chan_present;
  logic        s1_commit;

  rsch_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign chan_present = (int'(s1_item_r.channel) < CHANNELS);
  assign cur_st       = st_r[s1_item_r.channel];

  rsch_update u_update (
    .cfg  (cfg),
    .item (s1_item_r),
    .cur  (cur_st),
    .nxt  (nxt_st),
    .res  (res_nxt)
  );

  assign s1_advance = !out_valid_r || out_ready;
  assign s1_commit  = s1_valid_r && s1_advance && chan_present;
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.channel    <= in_channel;
      s1_item_r.now_ms     <= in_now_ms;
      s1_item_r.data_ready <= in_data_ready;
      s1_item_r.range_mm   <= in_range_mm;
      s1_item_r.init_ok    <= in_init_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r && chan_present;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        st_r[c] <= '0;
      end
    end else if (s1_commit) begin
      st_r[s1_item_r.channel] <= nxt_st;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_channel_out        = out_res_r.channel_out;
  assign out_health             = out_res_r.health;
  assign out_recovery_attempted = out_res_r.recovery_attempted;
  assign out_demote_reason      = out_res_r.demote_reason;
  assign out_sample_accepted    = out_res_r.sample_accepted;
  assign out_window_cleared     = out_res_r.window_cleared;
  assign out_window_count       = out_res_r.window_count;
  assign out_reading_valid      = out_res_r.reading_valid;

  // A trusted reading only ever comes from an online channel.
  a_valid_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.reading_valid |-> out_res_r.health == H_ONLINE)
    else $error("reading_valid set on a channel that is not online");

  // A demotion always leaves the channel offline with an empty window.
  a_demote_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.demote_reason != DEMOTE_NONE |->
      out_res_r.health == H_OFFLINE && out_res_r.window_cleared &&
      out_res_r.window_count == '0)
    else $error("demotion without offline state and cleared window");

  // A sample cannot be pushed in the same visit that empties the window.
  a_push_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.sample_accepted && out_res_r.window_cleared))
    else $error("sample accepted and window cleared together");

  // A recovery attempt starts from an empty window and demotes nothing.
  a_recovery_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.recovery_attempted |->
      out_res_r.window_cleared && out_res_r.window_count == '0 &&
      out_res_r.demote_reason == DEMOTE_NONE)
    else $error("recovery attempt left the window populated");

  // A committed visit shows up as a result in the following cycle.
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_commit |=> out_valid_r)
    else $error("committed item produced no result");

endmodule
